[sv/mhpq_pkg.sv]
// package for the min-heap priority queue: widths, opcodes, state encoding
// and the controller/datapath command and status structs; no dependencies
package mhpq_pkg;
  localparam int Depth = 64;
  localparam int AddrW = 6;
  localparam int CntW = 7;
  localparam int KeyW = 64;
  localparam int PayW = 16;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_LOOP, S_RD_P, S_RD_L, S_RD_R, S_DECIDE, S_WR_A, S_WR_B, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    RD_NONE, RD_POS, RD_LEFT, RD_RIGHT, RD_ROOT, RD_LAST
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    do_append;
    logic    pop_fix;
    logic    pop_wr_root;
    rd_sel_t rd_sel;
    logic    load_pos;
    logic    next_parent;
    logic    decide;
    logic    wr_a;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
    logic accept;
    logic parents_done;
    logic has_child;
    logic do_swap;
  } status_t;
endpackage

[sv/mhpq_if.sv]
// valid/ready channel interface carrying heap operations or results
// depends on mhpq_pkg for field widths
interface mhpq_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [mhpq_pkg::KeyW-1:0] key;
  logic [mhpq_pkg::PayW-1:0] payload;
  modport source (output valid, opcode, key, payload, input ready);
  modport sink (input valid, opcode, key, payload, output ready);
endinterface

interface mhpq_out_if;
  logic valid;
  logic ready;
  logic ok;
  logic [mhpq_pkg::KeyW-1:0] out_key;
  logic [mhpq_pkg::PayW-1:0] out_payload;
  logic [mhpq_pkg::CntW-1:0] count;
  modport source (output valid, ok, out_key, out_payload, count, input ready);
  modport sink (input valid, ok, out_key, out_payload, count, output ready);
endinterface

[sv/mhpq_ctrl.sv]
// controller state machine for the heap rebuild sequence
// depends on mhpq_pkg for state, command and status types
module mhpq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mhpq_pkg::status_t st,
  output mhpq_pkg::cmd_t    cmd
);
  mhpq_pkg::state_t state, state_next;
  logic out_full, out_full_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::S_IDLE;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      out_full <= out_full_next;
    end
  end

  assign out_valid = out_full;
  // a new transaction may enter while the previous result waits
  assign in_ready = (state == mhpq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.rd_sel = mhpq_pkg::RD_NONE;
    out_full_next = out_full && !out_ready;
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = mhpq_pkg::S_START;
        end
      end
      mhpq_pkg::S_START: begin
        if (!st.accept) begin
          state_next = mhpq_pkg::S_DONE;
        end else if (st.is_pop) begin
          cmd.rd_sel = mhpq_pkg::RD_ROOT;
          cmd.pop_fix = 1'b1;
          state_next = mhpq_pkg::S_WR_A;
        end else begin
          cmd.do_append = 1'b1;
          state_next = mhpq_pkg::S_LOOP;
        end
      end
      mhpq_pkg::S_LOOP: begin
        if (st.parents_done) begin
          state_next = mhpq_pkg::S_DONE;
        end else begin
          cmd.load_pos = 1'b1;
          state_next = mhpq_pkg::S_RD_P;
        end
      end
      mhpq_pkg::S_RD_P: begin
        if (st.has_child) begin
          cmd.rd_sel = mhpq_pkg::RD_POS;
          state_next = mhpq_pkg::S_RD_L;
        end else begin
          cmd.next_parent = 1'b1;
          state_next = mhpq_pkg::S_LOOP;
        end
      end
      mhpq_pkg::S_RD_L: begin
        cmd.rd_sel = mhpq_pkg::RD_LEFT;
        state_next = mhpq_pkg::S_RD_R;
      end
      mhpq_pkg::S_RD_R: begin
        cmd.rd_sel = mhpq_pkg::RD_RIGHT;
        state_next = mhpq_pkg::S_DECIDE;
      end
      mhpq_pkg::S_DECIDE: begin
        cmd.decide = 1'b1;
        if (st.do_swap) begin
          state_next = mhpq_pkg::S_WR_B;
        end else begin
          cmd.next_parent = 1'b1;
          state_next = mhpq_pkg::S_LOOP;
        end
      end
      mhpq_pkg::S_WR_B: begin
        cmd.wr_a = 1'b1;
        state_next = mhpq_pkg::S_RD_P;
      end
      mhpq_pkg::S_WR_A: begin
        // pop: capture the root read in S_START, read the last entry and move it to the root
        cmd.rd_sel = mhpq_pkg::RD_LAST;
        cmd.pop_wr_root = 1'b1;
        state_next = mhpq_pkg::S_LOOP;
      end
      mhpq_pkg::S_DONE: begin
        if (!out_full || out_ready) begin
          cmd.out_load = 1'b1;
          out_full_next = 1'b1;
          state_next = mhpq_pkg::S_IDLE;
        end
      end
      default: state_next = mhpq_pkg::S_IDLE;
    endcase
  end
endmodule

[sv/mhpq_dp.sv]
// datapath: heap store, count, capacity register and sift-down registers
// depends on mhpq_pkg; commanded by mhpq_ctrl
module mhpq_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mhpq_pkg::CntW-1:0]   cfg_data,
  input  logic                        in_opcode,
  input  logic [mhpq_pkg::KeyW-1:0]   in_key,
  input  logic [mhpq_pkg::PayW-1:0]   in_payload,
  input  mhpq_pkg::cmd_t              cmd,
  output mhpq_pkg::status_t           st,
  output logic                        res_ok,
  output logic [mhpq_pkg::KeyW-1:0]   res_key,
  output logic [mhpq_pkg::PayW-1:0]   res_payload,
  output logic [mhpq_pkg::CntW-1:0]   res_count
);
  localparam int EW = mhpq_pkg::KeyW + mhpq_pkg::PayW;
  logic [EW-1:0] mem [mhpq_pkg::Depth];
  logic [mhpq_pkg::CntW-1:0] capacity, cnt, parent, pos, child;
  logic op;
  logic [mhpq_pkg::KeyW-1:0] op_key, pop_key;
  logic [mhpq_pkg::PayW-1:0] op_pay, pop_pay;
  logic ok;
  logic [EW-1:0] rd_data, pos_e, l_e;
  logic [mhpq_pkg::CntW-1:0] rd_idx, limit, lpos, rpos;
  logic rd_en, wr_en;
  logic [mhpq_pkg::AddrW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic r_less, swap;
  logic [mhpq_pkg::CntW-1:0] cidx;
  logic [EW-1:0] c_e;
  logic [1:0] rd_tag;
  logic root_pend;
  logic res_ok_load;

  assign limit = (capacity < mhpq_pkg::CntW'(mhpq_pkg::Depth)) ? capacity
                                                              : mhpq_pkg::CntW'(mhpq_pkg::Depth);
  assign lpos = {pos[mhpq_pkg::CntW-2:0], 1'b0};
  assign rpos = lpos + 1'b1;

  // read address (1-based heap positions, stored 0-based)
  always_comb begin
    rd_en = 1'b1;
    rd_idx = '0;
    case (cmd.rd_sel)
      mhpq_pkg::RD_POS:   rd_idx = pos - 1'b1;
      mhpq_pkg::RD_LEFT:  rd_idx = lpos - 1'b1;
      mhpq_pkg::RD_RIGHT: rd_idx = (rpos <= cnt) ? rpos - 1'b1 : lpos - 1'b1;
      mhpq_pkg::RD_ROOT:  rd_idx = '0;
      mhpq_pkg::RD_LAST:  rd_idx = cnt;
      default:            rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_idx[mhpq_pkg::AddrW-1:0]];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) rd_tag <= '0;
    else rd_tag <= (cmd.rd_sel == mhpq_pkg::RD_POS) ? 2'd1 :
                   (cmd.rd_sel == mhpq_pkg::RD_LEFT) ? 2'd2 : 2'd0;
    if (rd_tag == 2'd1) pos_e <= rd_data;
    if (rd_tag == 2'd2) l_e <= rd_data;
  end

  // right child data is rd_data in S_DECIDE; equals left when absent
  assign r_less = (rpos <= cnt) && (rd_data[EW-1 -: mhpq_pkg::KeyW] < l_e[EW-1 -: mhpq_pkg::KeyW]);
  assign cidx = r_less ? rpos : lpos;
  assign c_e = r_less ? rd_data : l_e;
  assign swap = c_e[EW-1 -: mhpq_pkg::KeyW] < pos_e[EW-1 -: mhpq_pkg::KeyW];

  always_comb begin
    wr_en = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.do_append) begin
      wr_en = 1'b1;
      wr_addr = cnt[mhpq_pkg::AddrW-1:0];
      wr_data = {op_key, op_pay};
    end else if (cmd.decide && swap) begin
      wr_en = 1'b1;
      wr_addr = pos[mhpq_pkg::AddrW-1:0] - 1'b1;
      wr_data = c_e;
    end else if (cmd.wr_a) begin
      wr_en = 1'b1;
      wr_addr = child[mhpq_pkg::AddrW-1:0] - 1'b1;
      wr_data = pos_e;
    end else if (root_pend) begin
      // last entry read on the pop, moved into the root
      wr_en = 1'b1;
      wr_addr = '0;
      wr_data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= mhpq_pkg::CntW'(mhpq_pkg::Depth);
      cnt <= '0;
      root_pend <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (cmd.do_append) cnt <= cnt + 1'b1;
      if (cmd.pop_fix) cnt <= cnt - 1'b1;
      root_pend <= cmd.pop_wr_root;
    end
    if (cmd.capture) begin
      op <= in_opcode;
      op_key <= in_key;
      op_pay <= in_payload;
    end
    if (cmd.capture) ok <= 1'b0;
    else if (cmd.do_append || cmd.pop_fix) ok <= 1'b1;
    if (cmd.pop_wr_root) begin
      pop_key <= rd_data[EW-1 -: mhpq_pkg::KeyW];
      pop_pay <= rd_data[mhpq_pkg::PayW-1:0];
    end
    if (cmd.do_append || cmd.pop_wr_root) parent <= (cmd.do_append ? cnt + 1'b1 : cnt) >> 1;
    else if (cmd.next_parent) parent <= parent - 1'b1;
    if (cmd.load_pos) pos <= parent;
    if (cmd.decide && swap) begin
      child <= cidx;
      pos <= cidx;
    end
    if (res_ok_load) begin
      res_ok <= ok;
      res_key <= (ok && op == mhpq_pkg::OP_POP) ? pop_key : '0;
      res_payload <= (ok && op == mhpq_pkg::OP_POP) ? pop_pay : '0;
      res_count <= cnt;
    end
  end

  assign res_ok_load = cmd.out_load;

  assign st.is_pop = (op == mhpq_pkg::OP_POP);
  assign st.accept = (op == mhpq_pkg::OP_POP) ? (cnt != '0) : (cnt < limit);
  assign st.parents_done = (parent == '0);
  assign st.has_child = (lpos <= cnt) && (pos <= (cnt >> 1));
  assign st.do_swap = swap;
endmodule

[sv/min_heap_priority_queue_core.sv]
// Binary min-heap priority queue of 64-bit keys with 16-bit payloads.
// Channels: "in" carries opcode (0 push, 1 pop), key and payload; "out"
// returns ok, the popped key and payload (zero on push or refusal) and the
// entry count after the operation. Both are valid/ready; a transaction moves
// when valid and ready are high at a clock edge.
// cfg_we/cfg_data write the capacity register (reset 64, limit min(cap,64)).
// A push is refused when count reaches the limit; a pop on an empty heap is
// refused. Every accepted operation rebuilds the heap by a sift-down from
// each parent count/2 down to 1; each step reads the parent and its
// children and, on a swap, writes both entries and moves one level down.
// One operation is in flight at a time; the result sits in an output
// register, so the next operation is accepted while it waits. If the sink
// stalls, the core holds the following result until the register frees.
// Reset (rst, synchronous) empties the heap and sets capacity to 64; the
// store itself is not cleared.
// Depends on mhpq_pkg, mhpq_if, mhpq_ctrl and mhpq_dp.
module min_heap_priority_queue_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [mhpq_pkg::CntW-1:0]   cfg_data,
  mhpq_in_if.sink                     in_ch,
  mhpq_out_if.source                  out_ch
);
  mhpq_pkg::cmd_t cmd;
  mhpq_pkg::status_t st;

  mhpq_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .st, .cmd
  );

  mhpq_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_data,
    .in_opcode(in_ch.opcode), .in_key(in_ch.key), .in_payload(in_ch.payload),
    .cmd, .st,
    .res_ok(out_ch.ok), .res_key(out_ch.out_key),
    .res_payload(out_ch.out_payload), .res_count(out_ch.count)
  );
endmodule

[dv/tb_min_heap_priority_queue_core.sv]
// testbench for min_heap_priority_queue_core: push/pop traffic with random
// stalls, checked against a behavioral heap model in a scoreboard class
// depends on mhpq_pkg, mhpq_if and the core rtl
module tb_min_heap_priority_queue_core;
  typedef struct packed {
    logic                      ok;
    logic [mhpq_pkg::KeyW-1:0] key;
    logic [mhpq_pkg::PayW-1:0] pay;
    logic [mhpq_pkg::CntW-1:0] cnt;
  } heap_result_t;

  class heap_scoreboard;
    logic [mhpq_pkg::KeyW-1:0] keys[mhpq_pkg::Depth];
    logic [mhpq_pkg::PayW-1:0] pays[mhpq_pkg::Depth];
    int unsigned     held;
    int unsigned     cap;
    heap_result_t    pending[$];
    int              errors;

    function void clear();
      held = 0;
      cap = 64;
      errors = 0;
      pending.delete();
    endfunction

    function void swap_entries(int a, int b);
      logic [mhpq_pkg::KeyW-1:0] k;
      logic [mhpq_pkg::PayW-1:0] p;
      k = keys[a]; keys[a] = keys[b]; keys[b] = k;
      p = pays[a]; pays[a] = pays[b]; pays[b] = p;
    endfunction

    // sift-down from every parent, last parent first, 1-based positions
    function void reheapify();
      int pos;
      int c;
      for (int par = held / 2; par > 0; par--) begin
        pos = par;
        while (pos <= held / 2) begin
          c = 2 * pos;
          if (c + 1 <= held && keys[c] < keys[c-1]) c = c + 1;
          if (keys[c-1] < keys[pos-1]) begin
            swap_entries(c - 1, pos - 1);
            pos = c;
          end else break;
        end
      end
    endfunction

    function void note_op(logic op, logic [mhpq_pkg::KeyW-1:0] key,
                          logic [mhpq_pkg::PayW-1:0] pay);
      heap_result_t r;
      int unsigned lim;
      r = '0;
      lim = (cap < mhpq_pkg::Depth) ? cap : mhpq_pkg::Depth;
      if (op == mhpq_pkg::OP_PUSH) begin
        if (held < lim) begin
          keys[held] = key;
          pays[held] = pay;
          held++;
          reheapify();
          r.ok = 1'b1;
        end
      end else if (held > 0) begin
        r.key = keys[0];
        r.pay = pays[0];
        held--;
        keys[0] = keys[held];
        pays[0] = pays[held];
        reheapify();
        r.ok = 1'b1;
      end
      r.cnt = held[mhpq_pkg::CntW-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t exp;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.ok !== exp.ok) begin
        $error("ok: expected %0d actual %0d", exp.ok, got.ok); errors++;
      end
      if (got.key !== exp.key) begin
        $error("out_key: expected %h actual %h", exp.key, got.key); errors++;
      end
      if (got.pay !== exp.pay) begin
        $error("out_payload: expected %h actual %h", exp.pay, got.pay); errors++;
      end
      if (got.cnt !== exp.cnt) begin
        $error("count: expected %0d actual %0d", exp.cnt, got.cnt); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [mhpq_pkg::CntW-1:0] cfg_data = '0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  heap_scoreboard sb;

  mhpq_in_if in_ch ();
  mhpq_out_if out_ch ();

  min_heap_priority_queue_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = mhpq_pkg::OP_PUSH;
    in_ch.key = '0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stalls, checks each transaction
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.ok, out_ch.out_key, out_ch.out_payload, out_ch.count});
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays high between back-to-back transactions; drain drops it
  task automatic send_op(logic op, logic [mhpq_pkg::KeyW-1:0] key,
                         logic [mhpq_pkg::PayW-1:0] pay);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.key <= key;
    in_ch.payload <= pay;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_op(op, key, pay);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_capacity(logic [mhpq_pkg::CntW-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.cap = value;
  endtask

  // small keys, a few top-byte values and all-zero/all-one keys so equal keys collide, sometimes full-width ones
  function automatic logic [mhpq_pkg::KeyW-1:0] pick_key();
    case ($urandom_range(3))
      0: return mhpq_pkg::KeyW'($urandom_range(7));
      1: return {$urandom, $urandom};
      2: return {8'h61 + 8'($urandom_range(3)), 56'h0};
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  task automatic random_ops(int n, int push_pct);
    for (int i = 0; i < n; i++)
      send_op($urandom_range(99) < push_pct ? mhpq_pkg::OP_PUSH : mhpq_pkg::OP_POP,
              pick_key(), mhpq_pkg::PayW'($urandom));
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty pop, extremes, equal keys, full, capacity edge cases
    send_op(mhpq_pkg::OP_POP, '1, '1);
    send_op(mhpq_pkg::OP_PUSH, '1, '1);
    send_op(mhpq_pkg::OP_PUSH, '0, '0);
    send_op(mhpq_pkg::OP_PUSH, 64'h5, 16'h1111);
    send_op(mhpq_pkg::OP_PUSH, 64'h5, 16'h2222);
    send_op(mhpq_pkg::OP_PUSH, 64'h5, 16'h3333);
    for (int i = 0; i < 5; i++) send_op(mhpq_pkg::OP_POP, '0, '0);
    send_op(mhpq_pkg::OP_POP, '0, '0);
    set_capacity(7'd0);
    send_op(mhpq_pkg::OP_PUSH, 64'h1, 16'h1);
    set_capacity(7'd2);
    for (int i = 0; i < 3; i++) send_op(mhpq_pkg::OP_PUSH, 64'(3 - i), 16'(i));
    set_capacity(7'd1);
    send_op(mhpq_pkg::OP_PUSH, 64'h9, 16'h9);
    send_op(mhpq_pkg::OP_POP, '0, '0);
    send_op(mhpq_pkg::OP_POP, '0, '0);
    set_capacity(7'd127);

    // full run up to the store limit and refused push beyond
    send_idle_pct = 10; recv_idle_pct = 73;
    random_ops(66, 100);
    random_ops(40, 30);
    set_capacity(7'd64);
    random_ops(300, 55);
    drain();

    // sender idles often while the receiver is mostly ready
    send_idle_pct = 73; recv_idle_pct = 10;
    set_capacity(7'd5);
    random_ops(150, 60);
    set_capacity(7'd16);
    random_ops(300, 50);

    send_idle_pct = 0; recv_idle_pct = 0;
    set_capacity(7'd65);
    random_ops(150, 70);
    random_ops(150, 45);
    set_capacity(7'd64);
    random_ops(275, 40);
    drain();

    if (sb.errors == 0) $display("min_heap_priority_queue_core verification clean");
    else $display("min_heap_priority_queue_core verification failed");
    $finish;
  end

  initial begin
    #6000000;
    $display("min_heap_priority_queue_core verification failed");
    $finish;
  end
endmodule

[files.f]
sv/mhpq_pkg.sv
sv/mhpq_if.sv
sv/mhpq_ctrl.sv
sv/mhpq_dp.sv
sv/min_heap_priority_queue_core.sv
dv/tb_min_heap_priority_queue_core.sv
